FILE: hdl/sfr_pkg.sv
// Shared types, constants and a helper function for the stepped frequency ramp unit.
package sfr_pkg;

  // Default width of time values and interval products.
  localparam int unsigned TIME_BITS_DEF = 32;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_START_FREQ  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_COUNT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_IVAL   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MOVE_TIME   = 3'd4;

  // Field widths.
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned IVAL_W   = 24;
  localparam int unsigned MTIME_W  = 32;
  localparam int unsigned CMD_W    = 8;
  localparam int unsigned ELAPSE_W = 32;

  // Register reset values.
  localparam logic [FREQ_W-1:0]  START_FREQ_RST = 16'd400;
  localparam logic [COUNT_W-1:0] STEP_COUNT_RST = 8'd32;
  localparam logic [FREQ_W-1:0]  STEP_SIZE_RST  = 16'd100;
  localparam logic [IVAL_W-1:0]  STEP_IVAL_RST  = 24'd10000;
  localparam logic [MTIME_W-1:0] MOVE_TIME_RST  = 32'd0;

  // Request kinds carried on the input tuser.
  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_STOP = 1'b1;

  // Sequencer step counts: shift-add multiply over the 8-bit count or level,
  // restoring division producing a 10-bit quotient (bit 9 flags "512 or more").
  localparam int unsigned MUL_STEPS = 8;
  localparam int unsigned DIV_STEPS = 10;
  localparam int unsigned QUO_W     = 10;
  localparam int unsigned STEP_CNT_W = 4;

  // Command byte: frequency / 20, saturated at 255. For frequencies below 5120
  // the quotient is (f * 3277) >> 16, exact for every f below 16384.
  localparam logic [FREQ_W-1:0] CMD_SAT_FREQ = 16'd5120;
  localparam int unsigned       CMD_IN_W     = 13;
  localparam int unsigned       CMD_PROD_W   = 25;
  localparam logic [CMD_PROD_W-1:0] CMD_RECIP = 25'd3277;

  typedef struct packed {
    logic [FREQ_W-1:0]  start_freq;
    logic [COUNT_W-1:0] step_count;
    logic [FREQ_W-1:0]  step_size;
    logic [IVAL_W-1:0]  step_ival;
    logic [MTIME_W-1:0] move_time;
  } cfg_t;

  function automatic logic [CMD_W-1:0] cmd_of_freq(input logic [FREQ_W-1:0] f);
    logic [CMD_PROD_W-1:0] prod;
    prod = CMD_PROD_W'(f[CMD_IN_W-1:0]) * CMD_RECIP;
    if (f >= CMD_SAT_FREQ) begin
      return {CMD_W{1'b1}};
    end
    return prod[23:16];
  endfunction

endpackage

FILE: hdl/sfr_alu.sv
// Shared adder/subtractor used by the sequencer for its multiply, division and compare steps.
module sfr_alu #(
  parameter int unsigned W = 41
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         co_o
);

  logic [W:0] full;

  // For a subtraction the top bit is the borrow, set when a is below b.
  always_comb begin
    if (sub_i) begin
      full = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      full = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign res_o = full[W-1:0];
  assign co_o  = full[W];

endmodule

FILE: hdl/sfr_cfg.sv
// Configuration register file of the stepped frequency ramp unit.
module sfr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output sfr_pkg::cfg_t                  cfg_o
);

  sfr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_freq <= sfr_pkg::START_FREQ_RST;
      cfg_q.step_count <= sfr_pkg::STEP_COUNT_RST;
      cfg_q.step_size  <= sfr_pkg::STEP_SIZE_RST;
      cfg_q.step_ival  <= sfr_pkg::STEP_IVAL_RST;
      cfg_q.move_time  <= sfr_pkg::MOVE_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sfr_pkg::REG_START_FREQ: cfg_q.start_freq <= cfg_wdata_i[sfr_pkg::FREQ_W-1:0];
        sfr_pkg::REG_STEP_COUNT: cfg_q.step_count <= cfg_wdata_i[sfr_pkg::COUNT_W-1:0];
        sfr_pkg::REG_STEP_SIZE:  cfg_q.step_size  <= cfg_wdata_i[sfr_pkg::FREQ_W-1:0];
        sfr_pkg::REG_STEP_IVAL:  cfg_q.step_ival  <= cfg_wdata_i[sfr_pkg::IVAL_W-1:0];
        sfr_pkg::REG_MOVE_TIME:  cfg_q.move_time  <= cfg_wdata_i[sfr_pkg::MTIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/stepped_frequency_ramp_unit.sv
// Stepped trapezoidal frequency ramp: top level with the step sequencer.
// A stop word goes straight from the idle state to the output stage.
// One input word is handled at a time; the shared adder runs the ramp-length multiply,
// the level division and the frequency multiply in turn.
// The next word is accepted in the cycle after the previous one finishes.
// Reset (rst_ni low, asynchronous) clears the sequencer, the output valid and the
// stored frequency, and loads the registers with their default values.
module stepped_frequency_ramp_unit #(
  parameter int unsigned TIME_BITS = sfr_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input words.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // [31:0] elapsed_us
  input  logic [0:0]                     s_axis_tuser,   // [0] req_type
  // Result words.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,   // [7:0] command_byte, [23:8] frequency
  // Configuration writes.
  input  logic                           cfg_we_i,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // Time values live in TW bits; the shared adder is wide enough to hold the
  // interval shifted left by nine bits for the first division step.
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned UW = TIME_BITS + sfr_pkg::DIV_STEPS - 1;
  localparam int unsigned XW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};
  localparam int unsigned FW = sfr_pkg::FREQ_W;
  localparam int unsigned CW = sfr_pkg::COUNT_W;
  localparam int unsigned KW = sfr_pkg::STEP_CNT_W;
  localparam int unsigned QW = sfr_pkg::QUO_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RAMP = 4'd1;  // ramp length = interval * count
  localparam logic [3:0] ST_CHK1 = 4'd2;  // target - ramp length
  localparam logic [3:0] ST_CHK2 = 4'd3;  // elapsed below that difference?
  localparam logic [3:0] ST_CHK3 = 4'd4;  // target - elapsed, past target?
  localparam logic [3:0] ST_DIV  = 4'd5;  // level = numerator / interval
  localparam logic [3:0] ST_LVL  = 4'd6;  // cap or reject the level
  localparam logic [3:0] ST_MUL  = 4'd7;  // start + step * level
  localparam logic [3:0] ST_CMD  = 4'd8;  // saturate, compare, hand off

  // Saturate a 32-bit time value into TW bits.
  function automatic logic [TW-1:0] sat_time(input logic [31:0] v);
    logic [XW-1:0] ext;
    ext = XW'(v);
    if (ext > XW'(TMAX)) begin
      return TMAX;
    end
    return ext[TW-1:0];
  endfunction

  sfr_pkg::cfg_t cfg;

  sfr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  logic [3:0]    st_q;
  logic [TW-1:0] t_q, tgt_q, iv_q;
  logic [UW-1:0] acc_q;     // product accumulator, then remainder
  logic [UW-1:0] dv_q;      // shifting multiplicand or divisor
  logic [CW-1:0] cnt_q;     // multiplier bits, consumed from the bottom
  logic [KW-1:0] k_q;
  logic [QW-1:0] q_q;
  logic          ramp_ok_q, up_q, force_q;
  logic [FW-1:0] cur_q;
  logic          m_valid_q;
  logic [FW-1:0] m_freq_q;
  logic [sfr_pkg::CMD_W-1:0] m_cmd_q;

  logic [UW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_co;

  sfr_alu #(.W(UW)) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .res_o(alu_res),
    .co_o (alu_co)
  );

  logic [TW-1:0] ramp_sat;
  logic [FW-1:0] fr_sat;
  logic [sfr_pkg::CMD_W-1:0] fr_cmd;
  logic          emit_w, out_free, s_fire, q_over, out_load;

  assign ramp_sat = (acc_q[UW-1:TW] != '0) ? TMAX : acc_q[TW-1:0];
  assign fr_sat   = (acc_q[UW-1:FW] != '0) ? {FW{1'b1}} : acc_q[FW-1:0];
  assign fr_cmd   = sfr_pkg::cmd_of_freq(fr_sat);
  assign emit_w   = force_q || (fr_sat != cur_q);
  assign out_free = !m_valid_q || m_axis_tready;
  assign q_over   = q_q > QW'(cfg.step_count);
  // A new result word enters the output register in this cycle.
  assign out_load = (st_q == ST_CMD) && emit_w && out_free;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (st_q)
      ST_RAMP, ST_MUL: begin
        alu_a = acc_q;
        alu_b = dv_q;
      end
      ST_CHK1: begin
        alu_a   = UW'(tgt_q);
        alu_b   = UW'(ramp_sat);
        alu_sub = 1'b1;
      end
      ST_CHK2: begin
        alu_a   = UW'(t_q);
        alu_b   = UW'(acc_q[TW-1:0]);
        alu_sub = 1'b1;
      end
      ST_CHK3: begin
        alu_a   = UW'(tgt_q);
        alu_b   = UW'(t_q);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = acc_q;
        alu_b   = dv_q;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      m_valid_q <= 1'b0;
      cur_q     <= '0;
    end else begin
      // A word loaded in the same cycle as the old one drains keeps valid high.
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (s_fire) begin
            st_q <= (s_axis_tuser[0] == sfr_pkg::REQ_STOP) ? ST_CMD : ST_RAMP;
          end
        end
        ST_RAMP: begin
          if (k_q == KW'(sfr_pkg::MUL_STEPS - 1)) begin
            st_q <= ST_CHK1;
          end
        end
        ST_CHK1: st_q <= ST_CHK2;
        ST_CHK2: begin
          if (ramp_ok_q && alu_co) begin
            st_q <= (iv_q == '0) ? ST_IDLE : ST_DIV;
          end else begin
            st_q <= ST_CHK3;
          end
        end
        ST_CHK3: begin
          if (alu_co) begin
            st_q <= ST_CMD;
          end else if (iv_q == '0) begin
            st_q <= ST_MUL;
          end else begin
            st_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (k_q == KW'(sfr_pkg::DIV_STEPS - 1)) begin
            st_q <= ST_LVL;
          end
        end
        ST_LVL: st_q <= (up_q && q_over) ? ST_IDLE : ST_MUL;
        ST_MUL: begin
          if (k_q == KW'(sfr_pkg::MUL_STEPS - 1)) begin
            st_q <= ST_CMD;
          end
        end
        ST_CMD: begin
          if (!emit_w) begin
            st_q <= ST_IDLE;
          end else if (out_free) begin
            cur_q <= fr_sat;
            st_q  <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (s_fire) begin
          t_q     <= sat_time(s_axis_tdata);
          tgt_q   <= sat_time(cfg.move_time);
          iv_q    <= sat_time(32'(cfg.step_ival));
          acc_q   <= '0;
          dv_q    <= UW'(sat_time(32'(cfg.step_ival)));
          cnt_q   <= cfg.step_count;
          k_q     <= '0;
          force_q <= (s_axis_tuser[0] == sfr_pkg::REQ_STOP);
        end
      end
      ST_RAMP, ST_MUL: begin
        if (cnt_q[0]) begin
          acc_q <= alu_res;
        end
        dv_q  <= {dv_q[UW-2:0], 1'b0};
        cnt_q <= cnt_q >> 1;
        k_q   <= k_q + KW'(1);
      end
      ST_CHK1: begin
        ramp_ok_q <= !alu_co;
        acc_q     <= alu_res;
      end
      ST_CHK2: begin
        up_q  <= ramp_ok_q && alu_co;
        acc_q <= UW'(t_q);
        dv_q  <= UW'(iv_q) << (sfr_pkg::DIV_STEPS - 1);
        q_q   <= '0;
        k_q   <= '0;
      end
      ST_CHK3: begin
        k_q <= '0;
        if (alu_co) begin
          // Past the target: the frequency drops to zero.
          acc_q <= '0;
        end else if (iv_q == '0) begin
          acc_q <= UW'(cfg.start_freq);
          dv_q  <= UW'(cfg.step_size);
          cnt_q <= cfg.step_count;
        end else begin
          acc_q <= alu_res;
          dv_q  <= UW'(iv_q) << (sfr_pkg::DIV_STEPS - 1);
          q_q   <= '0;
        end
      end
      ST_DIV: begin
        if (!alu_co) begin
          acc_q <= alu_res;
        end
        q_q  <= {q_q[QW-2:0], !alu_co};
        dv_q <= dv_q >> 1;
        k_q  <= k_q + KW'(1);
      end
      ST_LVL: begin
        acc_q <= UW'(cfg.start_freq);
        dv_q  <= UW'(cfg.step_size);
        cnt_q <= q_over ? cfg.step_count : q_q[CW-1:0];
        k_q   <= '0;
      end
      ST_CMD: begin
        if (emit_w && out_free) begin
          m_freq_q <= fr_sat;
          m_cmd_q  <= fr_cmd;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_freq_q, m_cmd_q};

`ifndef SYNTH
  // The command byte is the frequency divided by twenty, or saturated.
  a_cmd_matches_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_cmd_q == 8'd255) ||
      (((20'(m_cmd_q) * 20'd20) <= 20'(m_freq_q)) &&
       (20'(m_freq_q) < (20'(m_cmd_q) * 20'd20 + 20'd20))))
    else $error("command byte does not match frequency");

  // A handed-off word updates the stored frequency to the same value.
  a_cur_tracks_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CMD && emit_w && out_free) |=> (cur_q == m_freq_q) && m_axis_tvalid)
    else $error("stored frequency differs from emitted word");

  // The division never runs past its last quotient bit.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (k_q < KW'(sfr_pkg::DIV_STEPS)))
    else $error("division step counter out of range");

  // A stop word always reaches the output stage next.
  a_stop_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser[0] == sfr_pkg::REQ_STOP) |=> (st_q == ST_CMD) && force_q)
    else $error("stop word did not go to output stage");
`endif

endmodule
